### design/nfba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfba_pkg: shared types and codes of the next-fit id allocator
// Beat payloads, opcodes, status codes, sequencer states and scan-unit
// control and result groups.
// ----------------------------------------------------------------------------
package nfba_pkg;

  // bitmap word width and bit index width
  localparam int MAP_W   = 64;
  localparam int BIT_W   = 6;
  // fixed field widths of the beats
  localparam int FIELD_ID_W = 10;
  localparam int STATUS_W   = 2;

  // opcodes
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_ALLOCATED   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EXHAUSTED   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RELEASED    = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_REL_IGNORED = 2'd3;

  // input beat
  typedef struct packed {
    logic                  opcode;
    logic [FIELD_ID_W-1:0] release_id;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic [FIELD_ID_W-1:0] granted_id;
    logic [STATUS_W-1:0]   status;
    logic                  has_wrapped;
  } out_item_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_RELEASE
  } state_t;

  // scan unit control: which cursor cut applies to the current word
  typedef struct packed {
    logic             lo_en;  // ignore bits below cut
    logic             hi_en;  // ignore bits at or above cut
    logic [BIT_W-1:0] cut;
  } scan_ctl_t;

  // scan unit result
  typedef struct packed {
    logic             hit;
    logic [BIT_W-1:0] bit_idx;
  } scan_res_t;

endpackage : nfba_pkg
`default_nettype wire

### design/nfba_map_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfba_map_ram: used-bitmap storage
// One write port and one read port, read data registered, one word per beat.
// ----------------------------------------------------------------------------
module nfba_map_ram
  import nfba_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [MAP_W-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [MAP_W-1:0] rd_data
);

  logic [MAP_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule : nfba_map_ram
`default_nettype wire

### design/nfba_word_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfba_word_scan: free-bit search over one bitmap word
// Applies the cursor cut to the word and returns the lowest free bit.
// ----------------------------------------------------------------------------
module nfba_word_scan
  import nfba_pkg::*;
(
  input  wire logic [MAP_W-1:0] word,
  input  wire scan_ctl_t        ctl,
  output scan_res_t             res
);

  logic [MAP_W-1:0] cut_mask;
  logic [MAP_W-1:0] allow;
  logic [MAP_W-1:0] free_bits;
  logic [MAP_W-1:0] lowest;

  // bits at or above the cut
  assign cut_mask = {MAP_W{1'b1}} << ctl.cut;

  // candidate free bits after the cursor cut
  always_comb begin
    allow = {MAP_W{1'b1}};
    if (ctl.lo_en) begin
      allow = allow & cut_mask;
    end
    if (ctl.hi_en) begin
      allow = allow & ~cut_mask;
    end
    free_bits = ~word & allow;
  end

  // isolate lowest free bit
  assign lowest = free_bits & (~free_bits + MAP_W'(1));

  // encode the one-hot position
  always_comb begin
    res.hit = |free_bits;
    for (int k = 0; k < BIT_W; k++) begin
      res.bit_idx[k] = 1'b0;
      for (int i = 0; i < MAP_W; i++) begin
        if (((i >> k) & 1) == 1) begin
          res.bit_idx[k] = res.bit_idx[k] | lowest[i];
        end
      end
    end
  end

endmodule : nfba_word_scan
`default_nettype wire

### design/next_fit_bitmap_id_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// next_fit_bitmap_id_allocator: next-fit identifier allocator
// Used-bitmap in a word memory, one shared word-scan unit under a sequencer.
// ----------------------------------------------------------------------------
// After reset the block clears its bitmap, one 64-bit word per cycle, and
// holds in_stall high meanwhile. It then takes one beat at a time. An
// allocate beat scans the bitmap one word per cycle through the single
// memory read port: from the cursor word to the top, then from word 0 up
// to the cursor word. A release beat reads and writes back one word. The
// result beat sits in an output register; ID_COUNT is a power of two from
// 128 to 1024, and granted ids are given in the low 10 bits of granted_id.
// ----------------------------------------------------------------------------
module next_fit_bitmap_id_allocator
  import nfba_pkg::*;
#(
  parameter int ID_COUNT = 1024
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  localparam int IdW       = $clog2(ID_COUNT);
  localparam int WordW     = IdW - BIT_W;
  localparam int MapWords  = ID_COUNT / MAP_W;
  localparam logic [WordW-1:0] LastWord = WordW'(MapWords - 1);
  localparam logic [IdW-1:0]   TopId    = IdW'(ID_COUNT - 1);

  // registers
  state_t             state_r, state_nxt;
  logic [WordW-1:0]   w_r, w_nxt;
  logic               phase2_r, phase2_nxt;
  logic [IdW-1:0]     cursor_r, cursor_nxt;
  logic               wrap_r, wrap_nxt;
  logic [WordW-1:0]   clr_r, clr_nxt;
  logic [BIT_W-1:0]   rel_bit_r, rel_bit_nxt;
  logic               rel_bad_r, rel_bad_nxt;
  logic               out_valid_r;
  out_item_t          out_data_r;

  // memory and scan signals
  logic               wr_en;
  logic [WordW-1:0]   wr_addr;
  logic [MAP_W-1:0]   wr_data;
  logic [WordW-1:0]   rd_addr;
  logic [MAP_W-1:0]   rd_data;
  scan_ctl_t          scan_ctl;
  scan_res_t          scan_res;

  // control helpers
  logic               load_out;
  out_item_t          res;
  logic               out_free;
  logic               at_end;
  logic [IdW-1:0]     hit_id;
  logic               hit_top;
  logic [WordW-1:0]   cur_word;
  logic [BIT_W-1:0]   cur_bit;
  logic [31:0]        rid_ext;
  logic [WordW-1:0]   rid_word;
  logic [BIT_W-1:0]   rid_bit;
  logic               rid_bad;

  // bitmap storage
  nfba_map_ram #(
    .DEPTH (MapWords),
    .AW    (WordW)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // shared word scan
  nfba_word_scan u_scan (
    .word (rd_data),
    .ctl  (scan_ctl),
    .res  (scan_res)
  );

  // cursor and release id split
  assign cur_word = cursor_r[IdW-1:BIT_W];
  assign cur_bit  = cursor_r[BIT_W-1:0];
  assign rid_ext  = 32'(in_data.release_id);
  assign rid_word = rid_ext[IdW-1:BIT_W];
  assign rid_bit  = rid_ext[BIT_W-1:0];
  assign rid_bad  = (rid_ext == 32'd0) || (rid_ext >= 32'(ID_COUNT));

  // cursor cut applies in the cursor word only
  assign scan_ctl.lo_en = !phase2_r && (w_r == cur_word);
  assign scan_ctl.hi_en = phase2_r && (w_r == cur_word);
  assign scan_ctl.cut   = cur_bit;

  // end of the current search range
  assign at_end  = phase2_r ? (w_r == cur_word) : (w_r == LastWord);
  assign hit_id  = {w_r, scan_res.bit_idx};
  assign hit_top = (hit_id == TopId);
  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_r == LastWord) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_data.opcode == OP_ALLOC) ? S_SCAN : S_RELEASE;
        end
      end
      S_SCAN: begin
        if ((scan_res.hit || (at_end && phase2_r)) && out_free) state_nxt = S_IDLE;
      end
      S_RELEASE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs and datapath next values
  always_comb begin
    in_stall    = 1'b1;
    rd_addr     = w_r;
    wr_en       = 1'b0;
    wr_addr     = w_r;
    wr_data     = rd_data;
    load_out    = 1'b0;
    res         = '0;
    w_nxt       = w_r;
    phase2_nxt  = phase2_r;
    cursor_nxt  = cursor_r;
    wrap_nxt    = wrap_r;
    clr_nxt     = clr_r;
    rel_bit_nxt = rel_bit_r;
    rel_bad_nxt = rel_bad_r;
    case (state_r)
      S_CLEAR: begin
        // id 0 stays marked used
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = (clr_r == '0) ? MAP_W'(1) : '0;
        clr_nxt = clr_r + WordW'(1);
      end
      S_IDLE: begin
        in_stall    = 1'b0;
        w_nxt       = (in_data.opcode == OP_ALLOC) ? cur_word : rid_word;
        rd_addr     = w_nxt;
        phase2_nxt  = 1'b0;
        rel_bit_nxt = rid_bit;
        rel_bad_nxt = rid_bad;
      end
      S_SCAN: begin
        if (scan_res.hit) begin
          // found a free id: mark it, move the cursor, report
          if (out_free) begin
            wr_en   = 1'b1;
            wr_data = rd_data | (MAP_W'(1) << scan_res.bit_idx);
            load_out = 1'b1;
            if (hit_top) begin
              cursor_nxt = IdW'(1);
              wrap_nxt   = 1'b1;
            end else begin
              cursor_nxt = hit_id + IdW'(1);
            end
            res.granted_id  = FIELD_ID_W'(hit_id);
            res.status      = STAT_ALLOCATED;
            res.has_wrapped = wrap_nxt;
          end
        end else if (at_end && !phase2_r) begin
          // upper range full: wrap to the bottom
          phase2_nxt = 1'b1;
          wrap_nxt   = 1'b1;
          w_nxt      = '0;
          rd_addr    = '0;
        end else if (at_end) begin
          // both ranges full
          if (out_free) begin
            load_out        = 1'b1;
            res.status      = STAT_EXHAUSTED;
            res.has_wrapped = wrap_r;
          end
        end else begin
          w_nxt   = w_r + WordW'(1);
          rd_addr = w_nxt;
        end
      end
      S_RELEASE: begin
        if (out_free) begin
          load_out        = 1'b1;
          wr_en           = !rel_bad_r;
          wr_data         = rd_data & ~(MAP_W'(1) << rel_bit_r);
          res.status      = rel_bad_r ? STAT_REL_IGNORED : STAT_RELEASED;
          res.has_wrapped = wrap_r;
        end
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      phase2_r    <= 1'b0;
      cursor_r    <= IdW'(1);
      wrap_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      phase2_r <= phase2_nxt;
      cursor_r <= cursor_nxt;
      wrap_r   <= wrap_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    w_r       <= w_nxt;
    rel_bit_r <= rel_bit_nxt;
    rel_bad_r <= rel_bad_nxt;
    if (load_out) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // no beat taken while the bitmap is being cleared
  a_no_accept_in_clear : assert property (
    @(posedge clk) disable iff (!rst_n) (state_r == S_CLEAR) |-> in_stall)
    else $error("input beat possible during clearing pass");

  // a result is loaded only into a free output register
  a_load_when_free : assert property (
    @(posedge clk) disable iff (!rst_n) load_out |-> (!out_valid_r || !out_stall))
    else $error("result overwrote a pending beat");

  // cursor never points at id 0
  a_cursor_nonzero : assert property (
    @(posedge clk) disable iff (!rst_n) (cursor_r != '0))
    else $error("cursor reached id 0");

  // id 0 is never granted
  a_grant_nonzero : assert property (
    @(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && wr_en) |-> (hit_id != '0))
    else $error("id 0 granted");

  // exhaustion always reports the wrap flag
  a_exhaust_wrapped : assert property (
    @(posedge clk) disable iff (!rst_n)
    (load_out && res.status == STAT_EXHAUSTED) |-> res.has_wrapped)
    else $error("exhausted without wrap flag");

endmodule : next_fit_bitmap_id_allocator
`default_nettype wire
